@@ hdl/chi_pkg.sv @@
package chi_pkg;

    localparam int DATA_W   = 32;
    localparam int WIDE_W   = 64;
    localparam int DIFF_W   = 33;
    localparam int DY3_W    = 35;
    localparam int MULP_W   = 65;
    localparam int PROD_W   = 97;
    localparam int NUM_W    = 68;
    localparam int DEN_W    = 65;
    localparam int STATUS_W = 2;
    localparam int KNOT_W   = 2;

    localparam logic [KNOT_W-1:0] KNOTS_FULL = 2'd2;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_ZERO = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_COEF,
        S_QUERY,
        S_MAG,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SAT,
        S_POST,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        STEP_NC,
        STEP_ND,
        STEP_HSQ,
        STEP_E1,
        STEP_E2,
        STEP_Y
    } step_t;

    typedef enum logic [1:0] {
        DIV_C,
        DIV_D1,
        DIV_D2
    } div_step_t;

    typedef struct packed {
        logic [WIDE_W-1:0] value;
        logic              sat;
    } sat_t;

    localparam logic [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
    localparam logic [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // signed value from a magnitude, clamped to 64 bits
    function automatic sat_t sat_mag(input logic [WIDE_W-1:0] low, input logic hi_nz,
                                     input logic neg);
        sat_t r;
        r.value = low;
        r.sat   = 1'b0;
        if (neg) begin
            if (hi_nz || (low > WIDE_MIN)) begin
                r.value = WIDE_MIN;
                r.sat   = 1'b1;
            end
            else begin
                r.value = {WIDE_W{1'b0}} - low;
            end
        end
        else if (hi_nz || low[WIDE_W-1]) begin
            r.value = WIDE_MAX;
            r.sat   = 1'b1;
        end
        return r;
    endfunction

    function automatic sat_t sat_add(input logic [WIDE_W-1:0] a, input logic [WIDE_W-1:0] b);
        sat_t            r;
        logic [WIDE_W:0] s;
        s       = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        r.value = s[WIDE_W-1:0];
        r.sat   = s[WIDE_W] ^ s[WIDE_W-1];
        if (r.sat) begin
            r.value = s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
        end
        return r;
    endfunction

endpackage

@@ hdl/cubic_hermite_interpolator_unit.sv @@
// cubic hermite interpolator, signed fixed point with FRAC_BITS fraction bits
// input channel in_valid/in_ready carries opcode, sample_time, knot_value, knot_slope;
// a load transfer shifts in a knot and recomputes the interval coefficients,
// a query transfer evaluates the cubic at sample_time and produces one result
// output channel out_valid/out_ready carries interp_value and status
// (0 ok, 1 fewer than two knots, 2 zero interval, 3 saturated)
// one item at a time: in_ready is high only while the sequencer is idle
// query: three passes through the shared 32x33 multiplier plus setup and result, each pass
// stepping through S_MAG, S_MUL0, S_MUL1, S_MUL2, S_SAT and S_POST
// load: three passes of the bit-serial divider, DVD_W = max(2 * FRAC_BITS + 67, 96) wide
// (99 at FRAC_BITS = 16), one quotient bit per cycle; the third pass is skipped when the
// cubic coefficient clamps early
// a load with fewer than two knots or a zero interval only clears the coefficients
// the result sits in an output register; a stalled receiver does not block
// further loads, and a query finishing into a full output register waits
// reset clears knots, coefficients and knot count, and drops out_valid
module cubic_hermite_interpolator_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [chi_pkg::DATA_W-1:0]    sample_time,
    input  logic [chi_pkg::DATA_W-1:0]    knot_value,
    input  logic [chi_pkg::DATA_W-1:0]    knot_slope,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [chi_pkg::DATA_W-1:0]    interp_value,
    output logic [chi_pkg::STATUS_W-1:0]  status
);

    import chi_pkg::*;

    localparam int SH2   = 2 * FRAC_BITS;
    localparam int QB_W  = WIDE_W + DIFF_W - 1 - SH2;
    localparam int DVD_W = (NUM_W - 1 + SH2 > WIDE_W + DIFF_W - 1) ? NUM_W - 1 + SH2
                                                                   : WIDE_W + DIFF_W - 1;

    state_t    state_reg, state_next;
    step_t     step_reg, step_next;
    div_step_t dstep_reg, dstep_next;

    logic [KNOT_W-1:0] knots_reg, knots_next;
    logic [DATA_W-1:0] left_time_reg, left_time_next;
    logic [DATA_W-1:0] left_value_reg, left_value_next;
    logic [DATA_W-1:0] left_slope_reg, left_slope_next;
    logic [DATA_W-1:0] right_time_reg, right_time_next;
    logic [DATA_W-1:0] right_value_reg, right_value_next;
    logic [DATA_W-1:0] right_slope_reg, right_slope_next;
    logic [WIDE_W-1:0] quad_coeff_reg, quad_coeff_next;
    logic [WIDE_W-1:0] cubic_coeff_reg, cubic_coeff_next;

    logic [DIFF_W-1:0] hd_reg, hd_next;
    logic [DIFF_W-1:0] dy_reg, dy_next;
    logic [DY3_W-1:0]  dy3_reg, dy3_next;
    logic [DIFF_W-1:0] hm_reg, hm_next;
    logic              hneg_reg, hneg_next;
    logic [WIDE_W-1:0] opa_reg, opa_next;
    logic [WIDE_W-1:0] ma_reg, ma_next;
    logic [DIFF_W-1:0] mb_reg, mb_next;
    logic              neg_reg, neg_next;
    logic [MULP_W-1:0] mp_reg, mp_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [WIDE_W-1:0] m_reg, m_next;
    logic [NUM_W-1:0]  sprod_reg, sprod_next;
    logic [NUM_W-1:0]  nc_reg, nc_next;
    logic [NUM_W-1:0]  nd_reg, nd_next;
    logic [DVD_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic              sat_reg, sat_next;
    status_t           st_reg, st_next;

    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   interp_value_reg, interp_value_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  div_quo;

    logic [DIFF_W-1:0] hd_mag;
    logic [31:0]       mul_x;
    logic [MULP_W-1:0] mul_p;
    logic [PROD_W-1:0] prod_sh;
    sat_t              mul_sat;
    logic [WIDE_W-1:0] add_base;
    sat_t              sum_sat;
    logic              dneg;
    logic              quo_neg;
    sat_t              quo_sat;
    sat_t              big_sat;
    logic              q1_big;
    logic [NUM_W-1:0]  nc_mag;
    logic [NUM_W-1:0]  nd_mag;
    logic [NUM_W-1:0]  dy3_ext;
    logic [NUM_W-1:0]  dy_ext;
    logic              y_ovf;
    logic [DATA_W-1:0] y_clamp;

    chi_div #(
        .DVD_W (DVD_W),
        .DSR_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign hd_mag = hd_reg[DIFF_W-1] ? ({DIFF_W{1'b0}} - hd_reg) : hd_reg;

    // shared multiplier, low half of the magnitude first
    assign mul_x = (state_reg == S_MUL0) ? ma_reg[31:0] : ma_reg[63:32];
    assign mul_p = MULP_W'(mul_x) * MULP_W'(mb_reg);

    assign prod_sh = (step_reg == STEP_E2) ? (acc_reg >> FRAC_BITS) : (acc_reg >> SH2);
    assign mul_sat = sat_mag(prod_sh[WIDE_W-1:0], |prod_sh[PROD_W-1:WIDE_W], neg_reg);

    always_comb
    begin
        case (step_reg)
            STEP_E1: add_base = quad_coeff_reg;
            STEP_E2: add_base = {{(DATA_W-FRAC_BITS){left_slope_reg[DATA_W-1]}},
                                 left_slope_reg, {FRAC_BITS{1'b0}}};
            default: add_base = {{(WIDE_W-DATA_W){left_value_reg[DATA_W-1]}}, left_value_reg};
        endcase
    end
    assign sum_sat = sat_add(add_base, m_reg);

    assign dneg    = nd_reg[NUM_W-1] ^ hneg_reg;
    assign quo_neg = (dstep_reg == DIV_C) ? nc_reg[NUM_W-1] : dneg;
    assign quo_sat = sat_mag(div_quo[WIDE_W-1:0], |div_quo[DVD_W-1:WIDE_W], quo_neg);
    assign big_sat = sat_mag({WIDE_W{1'b0}}, 1'b1, dneg);
    // quotient this large clamps after the last division for any interval length
    assign q1_big  = |div_quo[DVD_W-1:QB_W];

    assign nc_mag  = nc_reg[NUM_W-1] ? ({NUM_W{1'b0}} - nc_reg) : nc_reg;
    assign nd_mag  = nd_reg[NUM_W-1] ? ({NUM_W{1'b0}} - nd_reg) : nd_reg;
    assign dy3_ext = {{(NUM_W-DY3_W){dy3_reg[DY3_W-1]}}, dy3_reg};
    assign dy_ext  = {{(NUM_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};

    assign y_ovf   = !((&opa_reg[WIDE_W-1:DATA_W-1]) || !(|opa_reg[WIDE_W-1:DATA_W-1]));
    assign y_clamp = y_ovf ? (opa_reg[WIDE_W-1] ? DATA_MIN : DATA_MAX) : opa_reg[DATA_W-1:0];

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        dstep_next        = dstep_reg;
        knots_next        = knots_reg;
        left_time_next    = left_time_reg;
        left_value_next   = left_value_reg;
        left_slope_next   = left_slope_reg;
        right_time_next   = right_time_reg;
        right_value_next  = right_value_reg;
        right_slope_next  = right_slope_reg;
        quad_coeff_next   = quad_coeff_reg;
        cubic_coeff_next  = cubic_coeff_reg;
        hd_next           = hd_reg;
        dy_next           = dy_reg;
        dy3_next          = dy3_reg;
        hm_next           = hm_reg;
        hneg_next         = hneg_reg;
        opa_next          = opa_reg;
        ma_next           = ma_reg;
        mb_next           = mb_reg;
        neg_next          = neg_reg;
        mp_next           = mp_reg;
        acc_next          = acc_reg;
        m_next            = m_reg;
        sprod_next        = sprod_reg;
        nc_next           = nc_reg;
        nd_next           = nd_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        sat_next          = sat_reg;
        st_next           = st_reg;
        interp_value_next = interp_value_reg;
        status_next       = status_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        div_start         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (opcode_t'(opcode) == OP_LOAD) begin
                        left_time_next   = right_time_reg;
                        left_value_next  = right_value_reg;
                        left_slope_next  = right_slope_reg;
                        right_time_next  = sample_time;
                        right_value_next = knot_value;
                        right_slope_next = knot_slope;
                        if (knots_reg != KNOTS_FULL) begin
                            knots_next = knots_reg + 1'b1;
                        end
                        state_next = S_LOAD;
                    end
                    else begin
                        hd_next    = {sample_time[DATA_W-1], sample_time}
                                   - {left_time_reg[DATA_W-1], left_time_reg};
                        state_next = S_QUERY;
                    end
                end
            end

            S_LOAD: begin
                hd_next    = {right_time_reg[DATA_W-1], right_time_reg}
                           - {left_time_reg[DATA_W-1], left_time_reg};
                dy_next    = {right_value_reg[DATA_W-1], right_value_reg}
                           - {left_value_reg[DATA_W-1], left_value_reg};
                state_next = S_COEF;
            end

            S_COEF: begin
                if (knots_reg != KNOTS_FULL || hd_reg == '0) begin
                    quad_coeff_next  = '0;
                    cubic_coeff_next = '0;
                    state_next       = S_IDLE;
                end
                else begin
                    dy3_next   = {{2{dy_reg[DIFF_W-1]}}, dy_reg}
                               + {dy_reg[DIFF_W-1], dy_reg, 1'b0};
                    hm_next    = hd_mag;
                    hneg_next  = hd_reg[DIFF_W-1];
                    opa_next   = {{(WIDE_W-DATA_W-1){left_slope_reg[DATA_W-1]}},
                                  left_slope_reg, 1'b0}
                               + {{(WIDE_W-DATA_W){right_slope_reg[DATA_W-1]}},
                                  right_slope_reg};
                    step_next  = STEP_NC;
                    state_next = S_MAG;
                end
            end

            S_QUERY: begin
                sat_next = 1'b0;
                if (knots_reg != KNOTS_FULL) begin
                    opa_next   = '0;
                    st_next    = ST_FEW;
                    state_next = S_OUT;
                end
                else if (right_time_reg == left_time_reg) begin
                    opa_next   = '0;
                    st_next    = ST_ZERO;
                    state_next = S_OUT;
                end
                else begin
                    opa_next   = cubic_coeff_reg;
                    st_next    = ST_OK;
                    step_next  = STEP_E1;
                    state_next = S_MAG;
                end
            end

            S_MAG: begin
                ma_next    = opa_reg[WIDE_W-1] ? ({WIDE_W{1'b0}} - opa_reg) : opa_reg;
                mb_next    = hd_mag;
                neg_next   = opa_reg[WIDE_W-1] ^ hd_reg[DIFF_W-1];
                state_next = S_MUL0;
            end

            S_MUL0: begin
                mp_next    = mul_p;
                state_next = S_MUL1;
            end

            S_MUL1: begin
                mp_next    = mul_p;
                acc_next   = PROD_W'(mp_reg);
                state_next = S_MUL2;
            end

            S_MUL2: begin
                acc_next   = acc_reg + {mp_reg, 32'b0};
                state_next = S_SAT;
            end

            S_SAT: begin
                m_next     = mul_sat.value;
                sat_next   = sat_reg | mul_sat.sat;
                sprod_next = neg_reg ? ({NUM_W{1'b0}} - acc_reg[NUM_W-1:0])
                                     : acc_reg[NUM_W-1:0];
                state_next = S_POST;
            end

            S_POST: begin
                case (step_reg)
                    STEP_NC: begin
                        nc_next    = (dy3_ext << FRAC_BITS) - sprod_reg;
                        opa_next   = {{(WIDE_W-DATA_W){left_slope_reg[DATA_W-1]}},
                                      left_slope_reg}
                                   + {{(WIDE_W-DATA_W){right_slope_reg[DATA_W-1]}},
                                      right_slope_reg};
                        step_next  = STEP_ND;
                        state_next = S_MAG;
                    end
                    STEP_ND: begin
                        nd_next    = sprod_reg - (dy_ext << (FRAC_BITS + 1));
                        opa_next   = {{(WIDE_W-DIFF_W){1'b0}}, hm_reg};
                        step_next  = STEP_HSQ;
                        state_next = S_MAG;
                    end
                    STEP_HSQ: begin
                        num_next   = DVD_W'({nc_mag[NUM_W-2:0], {SH2{1'b0}}});
                        den_next   = acc_reg[DEN_W-1:0];
                        dstep_next = DIV_C;
                        state_next = S_DIV_GO;
                    end
                    STEP_E1: begin
                        opa_next   = sum_sat.value;
                        sat_next   = sat_reg | sum_sat.sat;
                        step_next  = STEP_E2;
                        state_next = S_MAG;
                    end
                    STEP_E2: begin
                        opa_next   = sum_sat.value;
                        sat_next   = sat_reg | sum_sat.sat;
                        step_next  = STEP_Y;
                        state_next = S_MAG;
                    end
                    STEP_Y: begin
                        opa_next   = sum_sat.value;
                        sat_next   = sat_reg | sum_sat.sat;
                        state_next = S_OUT;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_DIV_GO: begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT: begin
                if (div_done) begin
                    case (dstep_reg)
                        DIV_C: begin
                            quad_coeff_next = quo_sat.value;
                            num_next        = DVD_W'({nd_mag[NUM_W-2:0], {SH2{1'b0}}});
                            dstep_next      = DIV_D1;
                            state_next      = S_DIV_GO;
                        end
                        DIV_D1: begin
                            if (q1_big) begin
                                cubic_coeff_next = big_sat.value;
                                state_next       = S_IDLE;
                            end
                            else begin
                                num_next   = DVD_W'({div_quo[QB_W-1:0], {SH2{1'b0}}});
                                den_next   = {{(DEN_W-DIFF_W){1'b0}}, hm_reg};
                                dstep_next = DIV_D2;
                                state_next = S_DIV_GO;
                            end
                        end
                        DIV_D2: begin
                            cubic_coeff_next = quo_sat.value;
                            state_next       = S_IDLE;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next    = 1'b1;
                    interp_value_next = y_clamp;
                    if (st_reg != ST_OK) begin
                        status_next = st_reg;
                    end
                    else if (sat_reg || y_ovf) begin
                        status_next = ST_SAT;
                    end
                    else begin
                        status_next = ST_OK;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            step_reg        <= STEP_NC;
            dstep_reg       <= DIV_C;
            knots_reg       <= '0;
            left_time_reg   <= '0;
            left_value_reg  <= '0;
            left_slope_reg  <= '0;
            right_time_reg  <= '0;
            right_value_reg <= '0;
            right_slope_reg <= '0;
            quad_coeff_reg  <= '0;
            cubic_coeff_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            dstep_reg       <= dstep_next;
            knots_reg       <= knots_next;
            left_time_reg   <= left_time_next;
            left_value_reg  <= left_value_next;
            left_slope_reg  <= left_slope_next;
            right_time_reg  <= right_time_next;
            right_value_reg <= right_value_next;
            right_slope_reg <= right_slope_next;
            quad_coeff_reg  <= quad_coeff_next;
            cubic_coeff_reg <= cubic_coeff_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hd_reg           <= hd_next;
        dy_reg           <= dy_next;
        dy3_reg          <= dy3_next;
        hm_reg           <= hm_next;
        hneg_reg         <= hneg_next;
        opa_reg          <= opa_next;
        ma_reg           <= ma_next;
        mb_reg           <= mb_next;
        neg_reg          <= neg_next;
        mp_reg           <= mp_next;
        acc_reg          <= acc_next;
        m_reg            <= m_next;
        sprod_reg        <= sprod_next;
        nc_reg           <= nc_next;
        nd_reg           <= nd_next;
        num_reg          <= num_next;
        den_reg          <= den_next;
        sat_reg          <= sat_next;
        st_reg           <= st_next;
        interp_value_reg <= interp_value_next;
        status_reg       <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign interp_value = interp_value_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    a_knots_range: assert property (@(posedge clk) disable iff (!rst_n)
        knots_reg != 2'd3)
        else $error("knot count past two");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    a_zero_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COEF && hd_reg == '0) |=>
            (state_reg == S_IDLE && quad_coeff_reg == '0 && cubic_coeff_reg == '0))
        else $error("zero interval did not clear the coefficients");
`endif

endmodule

@@ hdl/chi_div.sv @@
module chi_div #(
    parameter int DVD_W = 99,
    parameter int DSR_W = 65
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DVD_W-1:0] quo_reg, quo_next;

    logic [DSR_W:0] trial;
    logic [DSR_W:0] diff;
    logic           ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg) begin
            rem_next = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("divider done without a running division");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dsr_reg))
        else $error("partial remainder not below divisor");
`endif

endmodule

@@ tb/sv/hermite_value_check.sv @@
module hermite_value_check #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          opcode,
    input  logic [chi_pkg::DATA_W-1:0]    sample_time,
    input  logic [chi_pkg::DATA_W-1:0]    knot_value,
    input  logic [chi_pkg::DATA_W-1:0]    knot_slope,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [chi_pkg::DATA_W-1:0]    interp_value,
    input  logic [chi_pkg::STATUS_W-1:0]  status,
    output int                            fail_count,
    output int                            pending_count
);

    localparam logic signed [63:0] WIDE_TOP      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] WIDE_BOTTOM   = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] NARROW_TOP    = 64'sd2147483647;
    localparam logic signed [63:0] NARROW_BOTTOM = -64'sd2147483648;
    localparam logic [127:0]       MAG_LIMIT     = 128'd1 << 63;

    typedef struct packed {
        logic [chi_pkg::DATA_W-1:0] value;
        chi_pkg::status_t           code;
    } hermite_result_t;

    logic signed [63:0] t_left  = '0;
    logic signed [63:0] y_left  = '0;
    logic signed [63:0] s_left  = '0;
    logic signed [63:0] t_right = '0;
    logic signed [63:0] y_right = '0;
    logic signed [63:0] s_right = '0;
    logic signed [63:0] c_quad  = '0;
    logic signed [63:0] d_cubic = '0;
    int                 n_knots = 0;
    int                 failures = 0;
    hermite_result_t    awaited[$];

    function automatic logic [63:0] abs_wide(input logic signed [63:0] a);
        return a[63] ? -a : a;
    endfunction

    function automatic logic signed [63:0] clamp_mag(input logic [127:0] m, input logic neg,
                                                     output logic hit);
        hit = 1'b0;
        if (neg)
        begin
            if (m > MAG_LIMIT)
            begin
                hit = 1'b1;
                return WIDE_BOTTOM;
            end
            return -$signed(m[63:0]);
        end
        if (m >= MAG_LIMIT)
        begin
            hit = 1'b1;
            return WIDE_TOP;
        end
        return $signed(m[63:0]);
    endfunction

    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                          input logic signed [63:0] b,
                                                          input int sh, output logic hit);
        logic [127:0] prod;
        prod = ({64'd0, abs_wide(a)} * {64'd0, abs_wide(b)}) >> sh;
        return clamp_mag(prod, a[63] ^ b[63], hit);
    endfunction

    function automatic logic signed [63:0] clamped_sum(input logic signed [63:0] a,
                                                       input logic signed [63:0] b,
                                                       output logic hit);
        logic signed [64:0] total;
        hit   = 1'b0;
        total = a + b;
        if (total > WIDE_TOP)
        begin
            hit = 1'b1;
            return WIDE_TOP;
        end
        if (total < WIDE_BOTTOM)
        begin
            hit = 1'b1;
            return WIDE_BOTTOM;
        end
        return total[63:0];
    endfunction

    function automatic void refresh_coeffs();
        logic signed [127:0] span, rise, sl0, sl1, num;
        logic [127:0]        span_mag, mag, q;
        logic                neg, ignored;
        c_quad  = '0;
        d_cubic = '0;
        if (n_knots < 2 || t_right == t_left)
            return;
        span     = t_right - t_left;
        rise     = y_right - y_left;
        sl0      = s_left;
        sl1      = s_right;
        span_mag = span[127] ? -span : span;

        num    = ((rise * 3) <<< FRAC_BITS) - (sl0 * 2 + sl1) * span;
        neg    = num[127];
        mag    = neg ? -num : num;
        q      = ((mag << (2 * FRAC_BITS)) / span_mag) / span_mag;
        c_quad = clamp_mag(q, neg, ignored);

        num = (sl0 + sl1) * span - ((rise * 2) <<< FRAC_BITS);
        neg = num[127];
        mag = neg ? -num : num;
        q   = ((mag << (2 * FRAC_BITS)) / span_mag) / span_mag;
        // third division would overflow: force saturation
        if ((q >> (127 - 2 * FRAC_BITS)) != 0)
            q = 128'd1 << 64;
        else
            q = (q << (2 * FRAC_BITS)) / span_mag;
        d_cubic = clamp_mag(q, neg ^ span[127], ignored);
    endfunction

    function automatic hermite_result_t evaluate_cubic(input logic signed [63:0] t);
        logic signed [63:0] h, p, e1, e2, y;
        logic               f0, f1, f2, f3, f4, f5, sat;
        hermite_result_t    r;
        r.value = '0;
        r.code  = chi_pkg::ST_OK;
        if (n_knots < 2)
        begin
            r.code = chi_pkg::ST_FEW;
            return r;
        end
        if (t_right == t_left)
        begin
            r.code = chi_pkg::ST_ZERO;
            return r;
        end
        h   = t - t_left;
        p   = scaled_product(d_cubic, h, 2 * FRAC_BITS, f0);
        e1  = clamped_sum(c_quad, p, f1);
        p   = scaled_product(e1, h, FRAC_BITS, f2);
        e2  = clamped_sum(s_left <<< FRAC_BITS, p, f3);
        p   = scaled_product(e2, h, 2 * FRAC_BITS, f4);
        y   = clamped_sum(y_left, p, f5);
        sat = f0 | f1 | f2 | f3 | f4 | f5;
        if (y > NARROW_TOP)
        begin
            y   = NARROW_TOP;
            sat = 1'b1;
        end
        if (y < NARROW_BOTTOM)
        begin
            y   = NARROW_BOTTOM;
            sat = 1'b1;
        end
        r.value = y[31:0];
        if (sat)
            r.code = chi_pkg::ST_SAT;
        return r;
    endfunction

    function automatic void flag_fault(input string what);
        failures++;
        if (failures <= 10)
            $display("%s", what);
    endfunction

    always @(posedge clk)
    begin
        hermite_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    flag_fault($sformatf("unexpected result transfer: value %h status %0d",
                                         interp_value, status));
                end
                else
                begin
                    want = awaited.pop_front();
                    if (interp_value !== want.value || status !== want.code)
                        flag_fault($sformatf(
                            "result mismatch: expected value %h status %0d, got value %h status %0d",
                            want.value, want.code, interp_value, status));
                end
            end
            if (in_valid && in_ready)
            begin
                if (opcode == chi_pkg::OP_LOAD)
                begin
                    t_left  = t_right;
                    y_left  = y_right;
                    s_left  = s_right;
                    t_right = $signed(sample_time);
                    y_right = $signed(knot_value);
                    s_right = $signed(knot_slope);
                    if (n_knots < 2)
                        n_knots++;
                    refresh_coeffs();
                end
                else
                begin
                    awaited.push_back(evaluate_cubic($signed(sample_time)));
                end
            end
        end
        pending_count <= awaited.size();
        fail_count    <= failures;
    end

endmodule

@@ tb/sv/cubic_hermite_interpolator_unit_test.sv @@
module cubic_hermite_interpolator_unit_test;

    localparam int          FRAC_BITS   = 16;
    localparam int          ITEM_COUNT  = 1400;
    localparam int          PHASE_LEN   = 200;
    localparam int          TAIL_CYCLES = 400;
    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          T_WRAP      = 32'sh1000_0000;
    localparam logic [31:0] ONE         = 32'h0001_0000;
    localparam logic [31:0] POS_END     = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_END     = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        opcode      = 1'b0;
    logic [31:0] sample_time = '0;
    logic [31:0] knot_value  = '0;
    logic [31:0] knot_slope  = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] interp_value;
    logic [1:0]  status;

    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   hold_left   = 0;
    int   t_prev      = 0;
    int   t_last      = 0;
    logic tx_gaps     = 1'b1;
    logic rx_stalls   = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cubic_hermite_interpolator_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .sample_time (sample_time),
        .knot_value  (knot_value),
        .knot_slope  (knot_slope),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .interp_value(interp_value),
        .status      (status)
    );

    hermite_value_check #(
        .FRAC_BITS(FRAC_BITS)
    ) u_value_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .sample_time  (sample_time),
        .knot_value   (knot_value),
        .knot_slope   (knot_slope),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .interp_value (interp_value),
        .status       (status),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always @(posedge clk)
    begin
        int pick;
        pick = $urandom_range(0, 99);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!rx_stalls || pick < 70)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= 1'b0;
            hold_left <= (pick < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cubic_hermite_interpolator_unit_test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_gaps || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] small_value();
        return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endfunction

    task automatic send(input chi_pkg::opcode_t op, input logic [31:0] t,
                        input logic [31:0] v, input logic [31:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        sample_time <= t;
        knot_value  <= v;
        knot_slope  <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 || !in_ready) @(posedge clk);
    endtask

    task automatic send_load(input logic [31:0] t, input logic [31:0] v,
                             input logic [31:0] s);
        send(chi_pkg::OP_LOAD, t, v, s);
        t_prev = t_last;
        t_last = t;
    endtask

    task automatic send_random();
        int          r;
        logic [31:0] t;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                if (t_last > T_WRAP || t_last < -T_WRAP)
                    t = -$urandom_range(0, 32'h0010_0000);
                else
                    t = t_last + $urandom_range(1, 32'h0003_0000);
            end
            else if (r < 78)
                t = t_last;
            else if (r < 86)
                t = t_last - $urandom_range(1, 32'h0003_0000);
            else
                t = $urandom;
            if (r < 86)
                send_load(t, small_value(), small_value());
            else
                send_load(t, $urandom, $urandom);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                t = t_prev + $urandom_range(0, 32'h0006_0000) - 32'h0001_0000;
            else if (r < 90)
                t = t_last + $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
            else
                t = $urandom;
            send(chi_pkg::OP_QUERY, t, $urandom, $urandom);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // no knots, then one knot
        send(chi_pkg::OP_QUERY, 32'd0, ALL_ONES, ALL_ONES);
        send_load(32'd0, 32'd0, ONE);
        send(chi_pkg::OP_QUERY, ONE, 32'd0, 32'd0);
        // zero-length interval
        send_load(32'd0, ONE, 32'd0);
        send(chi_pkg::OP_QUERY, 32'd0, ALL_ONES, 32'd0);
        // ordinary interval, inside and extrapolated
        send_load(ONE, 2 * ONE, ONE);
        send(chi_pkg::OP_QUERY, 32'd0, 32'd0, ALL_ONES);
        send(chi_pkg::OP_QUERY, ONE >> 1, 32'd0, 32'd0);
        send(chi_pkg::OP_QUERY, ONE, 32'd0, 32'd0);
        send(chi_pkg::OP_QUERY, 3 * ONE, 32'd0, 32'd0);
        send(chi_pkg::OP_QUERY, -ONE, 32'd0, 32'd0);
        // decreasing knot times
        send_load(-2 * ONE, -3 * ONE, 2 * ONE);
        send(chi_pkg::OP_QUERY, -ONE, 32'd0, 32'd0);
        send(chi_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0);
        // full-scale knots
        send_load(POS_END, POS_END, POS_END);
        send_load(NEG_END, NEG_END, NEG_END);
        send(chi_pkg::OP_QUERY, NEG_END, NEG_END, NEG_END);
        send(chi_pkg::OP_QUERY, POS_END, POS_END, POS_END);
        // one-lsb interval, clamped coefficients
        send_load(32'd0, 32'd0, POS_END);
        send_load(32'd1, POS_END, NEG_END);
        send(chi_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0);
        send(chi_pkg::OP_QUERY, POS_END, 32'd0, 32'd0);
        send(chi_pkg::OP_QUERY, 32'd1, 32'd0, 32'd0);

        for (int i = 0; i < ITEM_COUNT; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                drain();
                tx_gaps = ((i / PHASE_LEN) % 3) != 1;
                rx_stalls <= ((i / PHASE_LEN) % 3) != 2;
            end
            send_random();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("cubic_hermite_interpolator_unit_test passed");
        else
            $display("cubic_hermite_interpolator_unit_test failed");
        $finish;
    end

endmodule

@@ cubic_hermite_interpolator_unit.f @@
hdl/chi_pkg.sv
hdl/chi_div.sv
hdl/cubic_hermite_interpolator_unit.sv
tb/sv/hermite_value_check.sv
tb/sv/cubic_hermite_interpolator_unit_test.sv
